// ----- design/fraction_alu_reduce_defines.svh -----
// Assertion macros used by the fraction ALU top module, fraction_alu_reduce.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef FRACTION_ALU_REDUCE_DEFINES_SVH
`define FRACTION_ALU_REDUCE_DEFINES_SVH

// Same-cycle implication.
`define FAR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FAR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/far_pkg.sv -----
// Shared types and constants of the fraction ALU.
// No dependencies; used by far_div, fraction_alu_reduce and the testbench.
`default_nettype none
package far_pkg;
  localparam int MagW = 32;
  localparam int CntW = 6;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_CHK, ST_GCD, ST_DIVN, ST_DIVD, ST_FIN
  } state_t;

  typedef struct packed {
    logic            done;
    logic [MagW-1:0] quot;
  } div_stat_t;
endpackage
`default_nettype wire

// ----- design/far_cell.sv -----
// One bit cell of the divider's shift chain.
// Loads a dividend bit or takes its neighbor's bit on each shift.
`default_nettype none
module far_cell (
  input  wire logic clk,
  input  wire logic load,
  input  wire logic load_bit,
  input  wire logic shift,
  input  wire logic shift_in,
  output logic      bit_q
);
  logic bit_r;

  always_ff @(posedge clk) begin
    if (load) begin
      bit_r <= load_bit;
    end else if (shift) begin
      bit_r <= shift_in;
    end
  end

  assign bit_q = bit_r;
endmodule
`default_nettype wire

// ----- design/far_div.sv -----
// Restoring divider built on a chain of far_cell bit cells.
// The chain shifts the dividend out at the top and quotient bits in at the bottom.
// Depends on far_pkg and far_cell.
`default_nettype none
module far_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [far_pkg::MagW-1:0] dividend,
  input  wire logic [far_pkg::MagW-1:0] divisor,
  output far_pkg::div_stat_t            stat
);
  import far_pkg::*;

  logic [MagW-1:0] chain;
  logic [MagW-1:0] dsr_r;
  logic [MagW:0]   rem_r, rem_nxt, rem_sh;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic            step, qbit;

  assign step   = (cnt_r != '0);
  assign rem_sh = {rem_r[MagW-1:0], chain[MagW-1]};
  assign qbit   = (rem_sh >= {1'b0, dsr_r});

  genvar i;
  generate
    for (i = 0; i < MagW; i++) begin : g_cell
      if (i == 0) begin : g_first
        far_cell u_cell (.clk(clk), .load(start), .load_bit(dividend[i]),
                         .shift(step), .shift_in(qbit), .bit_q(chain[i]));
      end else begin : g_rest
        far_cell u_cell (.clk(clk), .load(start), .load_bit(dividend[i]),
                         .shift(step), .shift_in(chain[i-1]), .bit_q(chain[i]));
      end
    end
  endgenerate

  always_comb begin
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      cnt_nxt = CntW'(MagW);
    end else if (step) begin
      rem_nxt  = qbit ? (rem_sh - {1'b0, dsr_r}) : rem_sh;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign stat.done = done_r;
  assign stat.quot = chain;
endmodule
`default_nettype wire

// ----- design/fraction_alu_reduce.sv -----
// Fraction ALU: adds, subtracts, multiplies or divides two signed fractions
// and reduces the result to lowest terms.
// The input channel takes one beat with the operation and both fractions.
// The output channel gives one beat with the reduced numerator and
// denominator and an error flag; a zero denominator gives 0/0 with the flag.
// One item is worked on at a time: in_stall is high from acceptance until
// the result has been moved to the output register.
// After the MUL, SUM and CHK states an item runs through the binary GCD loop
// (one step per cycle) and then two divisions on the shared bit-cell divider.
// An error or a zero numerator skips the GCD and both divisions.
// Reset clears the control state and drops out_valid.
// When out_stall is high the result beat holds; the block may finish the
// next item meanwhile and waits for the output register to free up.
// Depends on far_pkg, far_div and far_cell.
`default_nettype none
module fraction_alu_reduce (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic signed [15:0] in_num_a,
  input  wire logic signed [15:0] in_den_a,
  input  wire logic signed [15:0] in_num_b,
  input  wire logic signed [15:0] in_den_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [32:0]      out_res_num,
  output logic signed [31:0]      out_res_den,
  output logic                    out_div_error
);
  import far_pkg::*;
  `include "fraction_alu_reduce_defines.svh"

  state_t state_r, state_nxt;

  logic [1:0]         op_r;
  logic signed [15:0] na_r, da_r, nb_r, db_r;
  logic signed [31:0] t1_r, t2_r, tden_r;
  logic signed [32:0] n_r;
  logic signed [31:0] d_r;
  logic               zop_r;
  logic [MagW-1:0]    ga_r, gb_r, g_r, qn_r;
  logic [4:0]         k_r;
  logic signed [32:0] rn_r;
  logic signed [31:0] rd_r;
  logic               re_r;
  logic               out_valid_r;
  logic signed [32:0] out_num_r;
  logic signed [31:0] out_den_r;
  logic               out_err_r;

  logic               accept, out_free, gcd_done;
  logic               div_start;
  logic [MagW-1:0]    div_dividend, div_divisor;
  div_stat_t          div_stat;
  logic signed [15:0] mx, my;
  logic signed [32:0] s_a, s_b, w1, w2;
  logic [MagW-1:0]    mag_n, mag_d;
  logic signed [32:0] qn_ext;
  logic signed [31:0] qd_s;

  assign out_free = !out_valid_r || !out_stall;
  assign gcd_done = (ga_r == gb_r);
  assign mx = (op_r == OP_MUL) ? nb_r : db_r;
  assign my = (op_r == OP_DIV) ? nb_r : db_r;
  assign s_a = 33'(na_r);
  assign s_b = 33'(nb_r);
  assign w1 = 33'(t1_r);
  assign w2 = 33'(t2_r);
  assign mag_n = n_r[32] ? MagW'(-n_r) : MagW'(n_r);
  assign mag_d = d_r[31] ? MagW'(-d_r) : MagW'(d_r);
  assign qn_ext = 33'({1'b0, qn_r});
  assign qd_s = $signed(div_stat.quot);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_CHK;
      ST_CHK: begin
        if (zop_r || d_r == '0 || n_r == '0) state_nxt = ST_FIN;
        else                                 state_nxt = ST_GCD;
      end
      ST_GCD:  if (gcd_done) state_nxt = ST_DIVN;
      ST_DIVN: if (div_stat.done) state_nxt = ST_DIVD;
      ST_DIVD: if (div_stat.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    div_start    = 1'b0;
    div_dividend = mag_n;
    div_divisor  = ga_r << k_r;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_GCD:  div_start = gcd_done;
      ST_DIVN: begin
        div_start    = div_stat.done;
        div_dividend = mag_d;
        div_divisor  = g_r;
      end
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  far_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_dividend), .divisor(div_divisor), .stat(div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      op_r <= in_req_type;
      na_r <= in_num_a;
      da_r <= in_den_a;
      nb_r <= in_num_b;
      db_r <= in_den_b;
    end
    unique case (state_r)
      ST_MUL: begin
        t1_r   <= 32'(na_r) * 32'(mx);
        t2_r   <= 32'(da_r) * 32'(nb_r);
        tden_r <= 32'(da_r) * 32'(my);
        zop_r  <= (da_r == '0) || (db_r == '0);
      end
      ST_SUM: begin
        if ((op_r == OP_ADD || op_r == OP_SUB) && da_r == db_r) begin
          n_r <= (op_r == OP_ADD) ? (s_a + s_b) : (s_a - s_b);
          d_r <= 32'(da_r);
        end else begin
          case (op_r)
            OP_ADD:  n_r <= w1 + w2;
            OP_SUB:  n_r <= w1 - w2;
            default: n_r <= w1;
          endcase
          d_r <= tden_r;
        end
      end
      ST_CHK: begin
        ga_r <= mag_n;
        gb_r <= mag_d;
        k_r  <= '0;
        if (zop_r || d_r == '0) begin
          rn_r <= '0;
          rd_r <= '0;
          re_r <= 1'b1;
        end else begin
          rn_r <= '0;
          rd_r <= d_r[31] ? -32'sd1 : 32'sd1;
          re_r <= 1'b0;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          g_r <= ga_r << k_r;
        end else if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          k_r  <= k_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (ga_r > gb_r) begin
          ga_r <= ga_r - gb_r;
        end else begin
          gb_r <= gb_r - ga_r;
        end
      end
      ST_DIVN: if (div_stat.done) qn_r <= div_stat.quot;
      ST_DIVD: begin
        if (div_stat.done) begin
          rn_r <= n_r[32] ? -qn_ext : qn_ext;
          rd_r <= d_r[31] ? -qd_s : qd_s;
          re_r <= 1'b0;
        end
      end
      default: ;
    endcase
    if (state_r == ST_FIN && out_free) begin
      out_num_r <= rn_r;
      out_den_r <= rd_r;
      out_err_r <= re_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_res_num   = out_num_r;
  assign out_res_den   = out_den_r;
  assign out_div_error = out_err_r;

  `FAR_ASSERT_NEXT(a_out_hold, out_valid_r && out_stall, out_valid_r, "result beat dropped")
  `FAR_ASSERT_NOW(a_err_zero, out_valid_r && out_err_r,
                  out_num_r == '0 && out_den_r == '0, "error beat not 0/0")
  `FAR_ASSERT_NOW(a_den_nz, out_valid_r && !out_err_r, out_den_r != '0, "zero denominator")
  `FAR_ASSERT_NOW(a_div_idle, div_stat.done, state_r == ST_DIVN || state_r == ST_DIVD,
                  "divider finished outside a division")
endmodule
`default_nettype wire

// ----- test/fraction_alu_reduce_tb.sv -----
// Self-checking testbench for fraction_alu_reduce: random and directed fraction beats
// are checked against a behavioral predictor of the add, subtract, multiply and divide.
// Depends on far_pkg and the fraction_alu_reduce design files.
`default_nettype none
module fraction_alu_reduce_tb;
  import far_pkg::*;

  typedef struct {
    logic signed [32:0] num;
    logic signed [31:0] den;
    logic               err;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_req_type = OP_ADD;
  logic signed [15:0] in_num_a = '0, in_den_a = '0, in_num_b = '0, in_den_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [32:0] out_res_num;
  logic signed [31:0] out_res_den;
  logic out_div_error;

  frac_res_t pending_q[$];
  int mismatches = 0;
  int sink_idle = 0;

  fraction_alu_reduce dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(logic [1:0] op, longint na, longint da,
                                                longint nb, longint db);
    frac_res_t r;
    longint n, d, g;
    r.err = 1'b1;
    r.num = '0;
    r.den = '0;
    if (da == 0 || db == 0) return r;
    case (op)
      OP_ADD: begin
        if (da != db) begin
          n = na * db + da * nb;
          d = da * db;
        end else begin
          n = na + nb;
          d = da;
        end
      end
      OP_SUB: begin
        if (da != db) begin
          n = na * db - da * nb;
          d = da * db;
        end else begin
          n = na - nb;
          d = da;
        end
      end
      OP_MUL: begin
        n = na * nb;
        d = da * db;
      end
      default: begin
        n = na * db;
        d = da * nb;
      end
    endcase
    if (d == 0) return r;
    if (n == 0) begin
      d = (d > 0) ? 1 : -1;
    end else begin
      g = longint'(gcd_mag(n < 0 ? -n : n, d < 0 ? -d : d));
      n = n / g;
      d = d / g;
    end
    r.err = 1'b0;
    r.num = n[32:0];
    r.den = d[31:0];
    return r;
  endfunction

  function automatic int random_gap();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  task automatic send_fraction(logic [1:0] op, logic [15:0] na, logic [15:0] da,
                               logic [15:0] nb, logic [15:0] db);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_q.push_back(reduce_fraction(op, $signed(na), $signed(da), $signed(nb),
                                        $signed(db)));
    in_valid <= 1'b1;
    in_req_type <= op;
    in_num_a <= na;
    in_den_a <= da;
    in_num_b <= nb;
    in_den_b <= db;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(8)) - 4);
      3: return 16'($urandom_range(64));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [15:0] ext[6];
    ext = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0000, 16'h0002};
    for (int op = 0; op < 4; op++) begin
      send_fraction(2'(op), 16'd2, 16'd2, 16'd2, 16'd2);
      send_fraction(2'(op), 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
      send_fraction(2'(op), 16'h7fff, 16'hffff, 16'h8000, 16'h7fff);
      send_fraction(2'(op), 16'd0, 16'hfffd, 16'd0, 16'd5);
    end
    send_fraction(OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
    send_fraction(OP_MUL, 16'd1, 16'd1, 16'd1, 16'd0);
    send_fraction(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd7);
    for (int i = 0; i < 6; i++)
      send_fraction(OP_SUB, ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 4) % 6]);
  endtask

  task automatic test_random();
    repeat (2000)
      send_fraction(2'($urandom), pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d/%0d", out_res_num,
                                       out_res_den);
      end else begin
        frac_res_t e;
        e = pending_q.pop_front();
        if (e.num !== out_res_num || e.den !== out_res_den || e.err !== out_div_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d err %0b, got %0d/%0d err %0b", e.num,
                     e.den, e.err, out_res_num, out_res_den, out_div_error);
        end
      end
    end
    if (sink_idle > 0) begin
      sink_idle <= sink_idle - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(9) < 3) begin
      sink_idle <= random_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("fraction_alu_reduce_tb OK");
    end else begin
      $display("fraction_alu_reduce_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("fraction_alu_reduce_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+design
design/far_pkg.sv
design/far_cell.sv
design/far_div.sv
design/fraction_alu_reduce.sv
test/fraction_alu_reduce_tb.sv
